### rtl/core/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

  // Field widths fixed by the link format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SETUP_CNT_W = 5;
  localparam int unsigned STORE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_HEADER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_PATTERN  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] PICTURE_HEADER_RST = 8'd1;
  localparam logic [BYTE_W-1:0] SETUP_HEADER_RST   = 8'd2;
  localparam logic [CFG_W-1:0]  SLEEP_PATTERN_RST  = 32'd0;

  // Request kinds
  localparam logic MODE_POLL = 1'b0;
  localparam logic MODE_SLOT = 1'b1;

  // Phase codes as reported on the result
  localparam logic [2:0] PHASE_IDLE      = 3'd0;
  localparam logic [2:0] PHASE_WAIT_SLOT = 3'd1;
  localparam logic [2:0] PHASE_HEADER    = 3'd2;
  localparam logic [2:0] PHASE_LINES     = 3'd3;
  localparam logic [2:0] PHASE_SETUP     = 3'd4;
  localparam logic [2:0] PHASE_WAIT_END  = 3'd5;

  typedef struct packed {
    logic              mode;
    logic              request_level;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] slot_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic              ready_line;
    logic              pixel_write;
    logic [2:0]        pixel_row;
    logic [2:0]        pixel_column;
    logic [1:0]        pixel_color;
    logic [BYTE_W-1:0] pixel_value;
    logic              balance_update;
    logic [BYTE_W-1:0] balance_first;
    logic [BYTE_W-1:0] balance_second;
    logic [BYTE_W-1:0] balance_third;
    logic              sleep_request;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/lfr_input_reg.sv
`default_nettype none

module lfr_input_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lfr_pkg::in_item_t in_data,
  input  wire logic             step,
  output logic                  held_valid,
  output lfr_pkg::in_item_t     held_item
);
  import lfr_pkg::*;

  // Take a new request when empty or when the held one moves on
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lfr_engine.sv
`default_nettype none

module lfr_engine #(
  parameter int SETUP_BYTES = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfr_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            step,
  input  wire lfr_pkg::in_item_t               item,
  output lfr_pkg::out_item_t                   result
);
  import lfr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_WAIT_SLOT = 6'b000010,
    ST_HEADER    = 6'b000100,
    ST_LINES     = 6'b001000,
    ST_SETUP     = 6'b010000,
    ST_WAIT_END  = 6'b100000
  } phase_t;

  // Configuration
  logic [BYTE_W-1:0] picture_header_code;
  logic [BYTE_W-1:0] setup_header_code;
  logic [CFG_W-1:0]  sleep_pattern;

  // Link state
  phase_t                 phase, phase_next, phase_eff;
  logic [3:0]             row_count, row_next, row_inc;
  logic [2:0]             column_count, column_next;
  logic [1:0]             color_count, color_next;
  logic [SETUP_CNT_W-1:0] setup_count, setup_next;
  logic                   sleep_latch, latch_next;
  logic                   line_level, line_next;
  logic [BYTE_W-1:0]      setup_store [STORE_DEPTH];
  logic [BYTE_W-1:0]      store_next [STORE_DEPTH];
  logic                   match_first, match_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      picture_header_code <= PICTURE_HEADER_RST;
      setup_header_code   <= SETUP_HEADER_RST;
      sleep_pattern       <= SLEEP_PATTERN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PICTURE_HEADER: picture_header_code <= cfg_data[BYTE_W-1:0];
        REG_SETUP_HEADER:   setup_header_code   <= cfg_data[BYTE_W-1:0];
        REG_SLEEP_PATTERN:  sleep_pattern       <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [2:0] phase_code(input phase_t p);
    case (p)
      ST_IDLE:      phase_code = PHASE_IDLE;
      ST_WAIT_SLOT: phase_code = PHASE_WAIT_SLOT;
      ST_HEADER:    phase_code = PHASE_HEADER;
      ST_LINES:     phase_code = PHASE_LINES;
      ST_SETUP:     phase_code = PHASE_SETUP;
      ST_WAIT_END:  phase_code = PHASE_WAIT_END;
      default:      phase_code = PHASE_IDLE;
    endcase
  endfunction

  assign row_inc = row_count + 4'd1;

  // Next state and result of the held request
  always_comb begin
    phase_next  = phase;
    row_next    = row_count;
    column_next = column_count;
    color_next  = color_count;
    setup_next  = setup_count;
    latch_next  = sleep_latch;
    line_next   = line_level;
    store_next  = setup_store;
    match_first = 1'b0;
    match_rest  = 1'b0;
    result      = '0;
    phase_eff   = item.request_level ? phase : ST_IDLE;

    if (item.mode == MODE_SLOT) begin
      // Slot start: any byte is dropped
      if (phase == ST_WAIT_SLOT) begin
        if (item.slot_number == '0) begin
          row_next    = '0;
          column_next = '0;
          color_next  = '0;
          setup_next  = '0;
          line_next   = 1'b0;
          phase_next  = ST_HEADER;
        end
      end else if (phase == ST_LINES) begin
        line_next = 1'b0;
      end
    end else begin
      phase_next = phase_eff;
      case (phase_eff)
        ST_IDLE: begin
          line_next = 1'b1;
          if (item.request_level) phase_next = ST_WAIT_SLOT;
        end
        ST_WAIT_SLOT: begin
          line_next = 1'b1;
        end
        ST_HEADER: begin
          line_next = 1'b0;
          if (item.byte_valid) begin
            if (item.byte_value == setup_header_code) phase_next = ST_SETUP;
            else if (item.byte_value == picture_header_code) phase_next = ST_LINES;
            else phase_next = ST_IDLE;
          end
        end
        ST_LINES: begin
          line_next = 1'b0;
          if (item.byte_valid) begin
            result.pixel_write  = 1'b1;
            result.pixel_row    = row_count[2:0];
            result.pixel_column = column_count;
            result.pixel_color  = color_count;
            result.pixel_value  = item.byte_value;
            // walk color, then column, then row
            if (color_count >= 2'd2) begin
              color_next = '0;
              if (column_count == 3'd7) begin
                column_next = '0;
                row_next    = row_inc;
                if (row_inc[3]) phase_next = ST_WAIT_END;
              end else begin
                column_next = column_count + 3'd1;
              end
            end else begin
              color_next = color_count + 2'd1;
            end
          end
        end
        ST_SETUP: begin
          line_next = 1'b0;
          if (item.byte_valid) begin
            if (setup_count < SETUP_CNT_W'(STORE_DEPTH)) begin
              store_next[setup_count[1:0]] = item.byte_value;
            end
            if (setup_count != '1) setup_next = setup_count + SETUP_CNT_W'(1);
            // Sleep pattern compare on the store as it stands after this byte
            match_first = store_next[0] == sleep_pattern[7:0];
            match_rest  = (store_next[1] == sleep_pattern[15:8]) &&
                          (store_next[2] == sleep_pattern[23:16]) &&
                          (store_next[3] == sleep_pattern[31:24]);
            // last setup byte: sleep pattern or white balance
            if (setup_next >= SETUP_CNT_W'(SETUP_BYTES)) begin
              if (match_first) begin
                if (match_rest) latch_next = 1'b1;
              end else if (store_next[0][7]) begin
                result.balance_update = 1'b1;
                result.balance_first  = store_next[1];
                result.balance_second = store_next[2];
                result.balance_third  = store_next[3];
              end
              phase_next = ST_WAIT_END;
            end
          end
        end
        ST_WAIT_END: begin
          line_next = 1'b0;
        end
        default: ;
      endcase
    end

    result.phase         = phase_code(phase_next);
    result.ready_line    = line_next;
    result.sleep_request = latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ST_IDLE;
      row_count    <= '0;
      column_count <= '0;
      color_count  <= '0;
      setup_count  <= '0;
      sleep_latch  <= 1'b0;
      line_level   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      row_count    <= row_next;
      column_count <= column_next;
      color_count  <= color_next;
      setup_count  <= setup_next;
      sleep_latch  <= latch_next;
      line_level   <= line_next;
    end
  end

  // Setup byte store, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      setup_store <= store_next;
    end
  end

  // Low request line on a poll always lands in idle
  assert property (@(posedge clk) disable iff (rst)
    step && item.mode == MODE_POLL && !item.request_level |=> phase == ST_IDLE)
    else $error("poll with low request did not return to idle");

  // Pixel writes only come from picture reception
  assert property (@(posedge clk) disable iff (rst)
    step && result.pixel_write |-> phase == ST_LINES)
    else $error("pixel write outside picture phase");

  // Sleep request is sticky until reset
  assert property (@(posedge clk) disable iff (rst)
    sleep_latch |=> sleep_latch)
    else $error("sleep latch dropped");

  // Balance update needs bit 7 of the first setup byte and ends setup
  assert property (@(posedge clk) disable iff (rst)
    step && result.balance_update |-> store_next[0][7] && phase_next == ST_WAIT_END)
    else $error("bad white balance update");

endmodule

`default_nettype wire

### rtl/core/led_frame_link_receiver_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        to core    in_valid / in_ready    in_data   (lfr_pkg::in_item_t)
// out       from core  out_valid / out_ready  out_data  (lfr_pkg::out_item_t)
// cfg       to core    cfg_we                 cfg_index, cfg_data
//
// One request per cycle sustained while out_ready stays high; a result passes
// through the input register, then the result register, before it is valid.
// The state update for a request is one pass of logic between those two registers.
// Synchronous reset clears state to idle and config to defaults.
// With out_ready low the result register holds; the input register takes
// at most one more request, then in_ready drops.

module led_frame_link_receiver_core #(
  parameter int SETUP_BYTES = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lfr_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lfr_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfr_pkg::CFG_W-1:0]     cfg_data
);
  import lfr_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  out_item_t result;
  logic      step;

  // Held request moves on when the result register is free or draining
  assign step = held_valid && (!out_valid || out_ready);

  lfr_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .step       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lfr_engine #(
    .SETUP_BYTES (SETUP_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_item),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### tb/tb_led_frame_link_receiver_core.sv
`default_nettype none

module tb_led_frame_link_receiver_core;
  import lfr_pkg::*;

  localparam int SETUP_BYTES = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 110;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  led_frame_link_receiver_core #(
    .SETUP_BYTES(SETUP_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Requests waiting to be driven, results waiting to be seen
  in_item_t pending_reqs[$];
  out_item_t predicted_results[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_items = 0;
  int unsigned results_seen = 0;
  int unsigned link_mismatches = 0;
  int unsigned cycle_count = 0;

  // Receiver state as the block should hold it
  logic [7:0] picture_code = PICTURE_HEADER_RST;
  logic [7:0] setup_code = SETUP_HEADER_RST;
  logic [31:0] sleep_code = SLEEP_PATTERN_RST;
  logic [2:0] link_phase = PHASE_IDLE;
  logic [3:0] row_cnt = '0;
  logic [2:0] col_cnt = '0;
  logic [1:0] color_cnt = '0;
  logic [4:0] setup_cnt = '0;
  logic [7:0] setup_bytes [4] = '{default: 8'h00};
  logic sleep_seen = 1'b0;
  logic line_busy = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the receiver state and return the result it gives
  function automatic out_item_t advance_receiver(input in_item_t rq);
    out_item_t r;
    r = '0;
    if (rq.mode == MODE_SLOT) begin
      // byte fields of a slot start are dropped
      if (link_phase == PHASE_WAIT_SLOT) begin
        if (rq.slot_number == 8'd0) begin
          row_cnt = '0;
          col_cnt = '0;
          color_cnt = '0;
          setup_cnt = '0;
          line_busy = 1'b0;
          link_phase = PHASE_HEADER;
        end
      end else if (link_phase == PHASE_LINES) begin
        line_busy = 1'b0;
      end
    end else begin
      if (!rq.request_level) link_phase = PHASE_IDLE;
      case (link_phase)
        PHASE_IDLE: begin
          line_busy = 1'b1;
          if (rq.request_level) link_phase = PHASE_WAIT_SLOT;
        end
        PHASE_WAIT_SLOT: line_busy = 1'b1;
        PHASE_HEADER: begin
          line_busy = 1'b0;
          // setup header wins when both codes are equal
          if (rq.byte_valid) begin
            if (rq.byte_value == setup_code) link_phase = PHASE_SETUP;
            else if (rq.byte_value == picture_code) link_phase = PHASE_LINES;
            else link_phase = PHASE_IDLE;
          end
        end
        PHASE_LINES: begin
          line_busy = 1'b0;
          if (rq.byte_valid) begin
            r.pixel_write = 1'b1;
            r.pixel_row = row_cnt[2:0];
            r.pixel_column = col_cnt;
            r.pixel_color = color_cnt;
            r.pixel_value = rq.byte_value;
            // walk color, then column, then row
            if (color_cnt >= 2'd2) begin
              color_cnt = '0;
              if (col_cnt == 3'd7) begin
                col_cnt = '0;
                row_cnt = row_cnt + 4'd1;
                if (row_cnt >= 4'd8) link_phase = PHASE_WAIT_END;
              end else begin
                col_cnt = col_cnt + 3'd1;
              end
            end else begin
              color_cnt = color_cnt + 2'd1;
            end
          end
        end
        PHASE_SETUP: begin
          line_busy = 1'b0;
          if (rq.byte_valid) begin
            if (setup_cnt < 5'd4) setup_bytes[setup_cnt[1:0]] = rq.byte_value;
            if (setup_cnt < 5'd31) setup_cnt = setup_cnt + 5'd1;
            if (setup_cnt >= 5'(SETUP_BYTES)) begin
              if (setup_bytes[0] == sleep_code[7:0]) begin
                if (setup_bytes[1] == sleep_code[15:8] &&
                    setup_bytes[2] == sleep_code[23:16] &&
                    setup_bytes[3] == sleep_code[31:24])
                  sleep_seen = 1'b1;
              end else if (setup_bytes[0][7]) begin
                r.balance_update = 1'b1;
                r.balance_first = setup_bytes[1];
                r.balance_second = setup_bytes[2];
                r.balance_third = setup_bytes[3];
              end
              link_phase = PHASE_WAIT_END;
            end
          end
        end
        PHASE_WAIT_END: line_busy = 1'b0;
        default: ;
      endcase
    end
    r.phase = link_phase;
    r.ready_line = line_busy;
    r.sleep_request = sleep_seen;
    return r;
  endfunction

  function automatic void queue_req(input logic mode, input logic req, input logic bv,
                                    input logic [7:0] value, input logic [7:0] slot);
    in_item_t it;
    it.mode = mode;
    it.request_level = req;
    it.byte_valid = bv;
    it.byte_value = value;
    it.slot_number = slot;
    pending_reqs.push_back(it);
    phase_items++;
  endfunction

  // Slot start with random byte fields, which the block must ignore
  function automatic void queue_slot(input logic [7:0] slot);
    queue_req(MODE_SLOT, 1'($urandom), 1'($urandom), 8'($urandom), slot);
  endfunction

  // Request that leaves an active transfer where it is
  function automatic void queue_filler();
    if ($urandom_range(1)) queue_req(MODE_POLL, 1'b1, 1'b0, 8'($urandom), 8'($urandom));
    else queue_slot(8'($urandom));
  endfunction

  // One transfer: request line low then up, slot zero, header, body, trailing polls
  function automatic void queue_transfer(input bit full_picture);
    int unsigned kind, count, style;
    logic [7:0] payload [4];
    queue_req(MODE_POLL, 1'b0, 1'($urandom), 8'($urandom), 8'($urandom));
    queue_req(MODE_POLL, 1'b1, 1'($urandom), 8'($urandom), 8'($urandom));
    repeat ($urandom_range(2)) begin
      if ($urandom_range(1)) queue_slot(8'($urandom_range(255, 1)));
      else queue_req(MODE_POLL, 1'b1, 1'($urandom), 8'($urandom), 8'($urandom));
    end
    queue_slot(8'd0);
    if ($urandom_range(3) == 0) queue_filler();
    kind = full_picture ? 0 : $urandom_range(9);
    if (kind < 4) begin
      queue_req(MODE_POLL, 1'b1, 1'b1, picture_code, 8'($urandom));
      count = full_picture ? 192 + $urandom_range(3) : $urandom_range(30, 1);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(7) == 0) queue_filler();
        if (!full_picture && $urandom_range(24) == 0) begin
          queue_req(MODE_POLL, 1'b0, 1'($urandom), 8'($urandom), 8'($urandom));
          return;
        end
        queue_req(MODE_POLL, 1'b1, 1'b1, 8'($urandom), 8'($urandom));
      end
    end else if (kind < 9) begin
      queue_req(MODE_POLL, 1'b1, 1'b1, setup_code, 8'($urandom));
      for (int i = 0; i < 4; i++) payload[i] = 8'($urandom);
      style = $urandom_range(9);
      if (style == 0) begin
        for (int i = 0; i < 4; i++) payload[i] = sleep_code[8*i +: 8];
      end else if (style < 3) begin
        payload[0] = sleep_code[7:0];
      end else if (style < 6) begin
        payload[0][7] = 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(5) == 0) queue_filler();
        if ($urandom_range(29) == 0) begin
          queue_req(MODE_POLL, 1'b0, 1'($urandom), 8'($urandom), 8'($urandom));
          return;
        end
        queue_req(MODE_POLL, 1'b1, 1'b1, payload[i], 8'($urandom));
      end
    end else begin
      // most likely an unknown header
      queue_req(MODE_POLL, 1'b1, 1'b1, 8'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(2))
      queue_req(MODE_POLL, 1'b1, 1'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PICTURE_HEADER: picture_code = value[7:0];
      REG_SETUP_HEADER: setup_code = value[7:0];
      REG_SLEEP_PATTERN: sleep_code = value;
      default: ;
    endcase
  endtask

  // Block is idle once every request is through and every result is back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_results.push_back(advance_receiver(in_data));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    string bad;
    results_seen++;
    if (predicted_results.size() == 0) begin
      link_mismatches++;
      if (link_mismatches <= 10) $display("result %0d with none pending: %h", results_seen, got);
      return;
    end
    want = predicted_results.pop_front();
    bad = "";
    if (got.phase !== want.phase) bad = {bad, " phase"};
    if (got.ready_line !== want.ready_line) bad = {bad, " ready_line"};
    if (got.pixel_write !== want.pixel_write) bad = {bad, " pixel_write"};
    if (got.pixel_row !== want.pixel_row) bad = {bad, " pixel_row"};
    if (got.pixel_column !== want.pixel_column) bad = {bad, " pixel_column"};
    if (got.pixel_color !== want.pixel_color) bad = {bad, " pixel_color"};
    if (got.pixel_value !== want.pixel_value) bad = {bad, " pixel_value"};
    if (got.balance_update !== want.balance_update) bad = {bad, " balance_update"};
    if (got.balance_first !== want.balance_first) bad = {bad, " balance_first"};
    if (got.balance_second !== want.balance_second) bad = {bad, " balance_second"};
    if (got.balance_third !== want.balance_third) bad = {bad, " balance_third"};
    if (got.sleep_request !== want.sleep_request) bad = {bad, " sleep_request"};
    if (bad != "") begin
      link_mismatches++;
      if (link_mismatches <= 10)
        $display("result %0d mismatch:%s expected %h got %h", results_seen, bad, want, got);
    end
  endfunction

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus: directed requests, then random phases under different settings
  initial begin
    logic [7:0] code_a, code_b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // line high in idle, wait slot, ignored slot starts, unknown header
    queue_req(MODE_POLL, 1'b0, 1'b1, 8'hff, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b0, 8'h00, 8'hff);
    queue_req(MODE_SLOT, 1'b1, 1'b1, 8'haa, 8'hff);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h01, 8'h00);
    queue_req(MODE_SLOT, 1'b0, 1'b1, 8'h55, 8'h00);
    queue_req(MODE_SLOT, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b0, 8'h01, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h7f, 8'h00);
    // picture, byte lost with a slot start, aborted by request low
    queue_req(MODE_POLL, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_req(MODE_SLOT, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, PICTURE_HEADER_RST, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h00, 8'h00);
    queue_req(MODE_SLOT, 1'b1, 1'b1, 8'h55, 8'h07);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'hff, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b0, 8'h33, 8'h00);
    queue_req(MODE_POLL, 1'b0, 1'b1, 8'h44, 8'h00);
    // setup block giving a balance update, then bytes in wait end
    queue_req(MODE_POLL, 1'b1, 1'b0, 8'h00, 8'h00);
    queue_req(MODE_SLOT, 1'b0, 1'b0, 8'h00, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, SETUP_HEADER_RST, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h80, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h00, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'hff, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h12, 8'h00);
    queue_req(MODE_POLL, 1'b1, 1'b1, 8'h9c, 8'h00);
    queue_req(MODE_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PICTURE_HEADER, 32'h0000_0000);
          write_reg(REG_SETUP_HEADER, 32'h0000_00ff);
          write_reg(REG_SLEEP_PATTERN, 32'hffff_ffff);
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_PICTURE_HEADER, 32'h0000_00ff);
          write_reg(REG_SETUP_HEADER, 32'h0000_0000);
          write_reg(REG_SLEEP_PATTERN, 32'h0000_0000);
          send_gap_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          // equal header codes
          code_a = 8'($urandom);
          write_reg(REG_PICTURE_HEADER, {24'h0, code_a});
          write_reg(REG_SETUP_HEADER, {24'h0, code_a});
          write_reg(REG_SLEEP_PATTERN, $urandom);
          send_gap_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          code_a = 8'($urandom);
          do code_b = 8'($urandom); while (code_b == code_a);
          write_reg(REG_PICTURE_HEADER, {24'h0, code_a});
          write_reg(REG_SETUP_HEADER, {24'h0, code_b});
          write_reg(REG_SLEEP_PATTERN, $urandom);
          write_reg(REG_SPARE, $urandom);
          send_gap_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      phase_items = 0;
      if (ph < 2) queue_transfer(1'b1);
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(6) == 0) begin
          // noise burst
          repeat ($urandom_range(6, 1))
            queue_req(1'($urandom), $urandom_range(3) != 0, 1'($urandom), 8'($urandom),
                      ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
        end else begin
          queue_transfer(1'b0);
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (link_mismatches == 0 && predicted_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### led_frame_link_receiver_core.f
rtl/core/lfr_pkg.sv
rtl/core/lfr_input_reg.sv
rtl/core/lfr_engine.sv
rtl/core/led_frame_link_receiver_core.sv
tb/tb_led_frame_link_receiver_core.sv
